// ----- design/satm_pkg.sv -----
`timescale 1ns / 1ps
package satm_pkg;

  // Default geometry. MAX_SETS and WAYS must be powers of two: set and victim
  // selection reduce their operands with a mask.
  localparam int DEF_MAX_SETS  = 256;
  localparam int DEF_WAYS      = 4;
  localparam int DEF_ADDR_BITS = 32;

  localparam int CYCLE_W    = 64;
  localparam int ADDR_W     = 32;
  localparam int LAT_W      = 16;
  localparam int CNT_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SHIFT_W    = 4;
  localparam int POLICY_W   = 2;

  localparam logic [SHIFT_W-1:0]  RST_OFFSET_BITS = 4'd5;
  localparam logic [SHIFT_W-1:0]  RST_INDEX_BITS  = 4'd8;
  localparam logic [LAT_W-1:0]    RST_HIT_LAT     = 16'd1;
  localparam logic [LAT_W-1:0]    RST_MISS_LAT    = 16'd100;

  localparam logic [POLICY_W-1:0] POLICY_LRU    = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_FIFO   = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_RANDOM = 2'd2;

  localparam int              LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 3'd0,
    CFG_INDEX_BITS  = 3'd1,
    CFG_POLICY      = 3'd2,
    CFG_HIT_LAT     = 3'd3,
    CFG_MISS_LAT    = 3'd4
  } cfg_idx_t;

  // Event handed from the lookup stage to the statistics counters.
  typedef struct packed {
    logic fire;
    logic miss;
  } upd_t;

endpackage

// ----- design/satm_set_ram.sv -----
`timescale 1ns / 1ps
module satm_set_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  output logic          rd_live,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DW-1:0]    rd_data_r;
  logic             rd_live_r;
  logic [DEPTH-1:0] live_r;

  // A row that was never written reads as not live; the lookup then uses
  // the reset contents of a set instead of the array data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_live_r <= live_r[rd_addr];
      end
      if (wr_en) begin
        live_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_live = rd_live_r;

endmodule

// ----- design/satm_lookup.sv -----
`timescale 1ns / 1ps
module satm_lookup #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 32,
  parameter int ROW_W = 4 * 32 + 4 + 4 * 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [satm_pkg::POLICY_W-1:0]  policy,
  input  logic [TAG_W-1:0]               tag,
  input  logic [ROW_W-1:0]               row_in,
  input  logic                           row_live,
  output logic                           hit,
  output logic [ROW_W-1:0]               row_out
);
  import satm_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0][TAG_W-1:0] tags, tags_n;
  logic [WAYS-1:0]            vld, vld_n;
  logic [WAYS-1:0][WAY_W-1:0] ord, ord_n;
  logic [LFSR_W-1:0]          lfsr_r, lfsr_nxt;
  logic [LFSR_W-1:0]          lfsr_step;
  logic                       found;
  logic [WAY_W-1:0]           hpos, vpos, mpos, vway;
  logic                       do_move;

  // Galois step of the victim LFSR.
  assign lfsr_step = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  always_comb begin
    if (row_live) begin
      {tags, vld, ord} = row_in;
    end else begin
      tags = '0;
      vld  = '0;
      for (int i = 0; i < WAYS; i++) begin
        ord[i] = WAY_W'(i);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    hpos  = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (!found && vld[ord[p]] && (tags[ord[p]] == tag)) begin
        found = 1'b1;
        hpos  = WAY_W'(p);
      end
    end

    if (policy == POLICY_RANDOM) begin
      vpos = WAY_W'(lfsr_step & LFSR_W'(WAYS - 1));
    end else begin
      vpos = WAY_W'(WAYS - 1);
    end
    vway = ord[vpos];

    tags_n = tags;
    vld_n  = vld;
    if (!found) begin
      tags_n[vway] = tag;
      vld_n[vway]  = 1'b1;
    end

    mpos    = found ? hpos : vpos;
    do_move = !found || (policy == POLICY_LRU);
    ord_n   = ord;
    if (do_move) begin
      for (int i = 0; i < WAYS; i++) begin
        if (i == 0) begin
          ord_n[i] = ord[mpos];
        end else if (WAY_W'(i) <= mpos) begin
          ord_n[i] = ord[i-1];
        end else begin
          ord_n[i] = ord[i];
        end
      end
    end

    lfsr_nxt = lfsr_r;
    if (fire && !found && (policy == POLICY_RANDOM)) begin
      lfsr_nxt = lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

  assign hit     = found;
  assign row_out = {tags_n, vld_n, ord_n};

endmodule

// ----- design/satm_stats.sv -----
`timescale 1ns / 1ps
module satm_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  satm_pkg::upd_t                ev,
  input  logic [satm_pkg::CYCLE_W-1:0]  cycle_stamp,
  input  logic [satm_pkg::LAT_W-1:0]    miss_latency,
  output logic [satm_pkg::CNT_W-1:0]    access_total,
  output logic [satm_pkg::CNT_W-1:0]    miss_total,
  output logic [satm_pkg::CNT_W-1:0]    distinct_total
);
  import satm_pkg::*;

  logic [CNT_W-1:0]   access_r, miss_r, distinct_r;
  logic [CNT_W-1:0]   access_nxt, miss_nxt, distinct_nxt;
  logic [CYCLE_W-1:0] last_miss_r, last_miss_nxt;
  logic               seen_r, seen_nxt;
  logic [CYCLE_W-1:0] gap;
  logic               distinct;

  // A miss starts a new window when none came before or the last counted
  // one lies more than the miss latency back (modular distance).
  assign gap      = cycle_stamp - last_miss_r;
  assign distinct = !seen_r || (gap > CYCLE_W'(miss_latency));

  always_comb begin
    access_nxt    = access_r;
    miss_nxt      = miss_r;
    distinct_nxt  = distinct_r;
    last_miss_nxt = last_miss_r;
    seen_nxt      = seen_r;
    if (ev.fire) begin
      access_nxt = access_r + 1'b1;
      if (ev.miss) begin
        miss_nxt = miss_r + 1'b1;
        if (distinct) begin
          distinct_nxt  = distinct_r + 1'b1;
          last_miss_nxt = cycle_stamp;
          seen_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_r    <= '0;
      miss_r      <= '0;
      distinct_r  <= '0;
      last_miss_r <= '0;
      seen_r      <= 1'b0;
    end else begin
      access_r    <= access_nxt;
      miss_r      <= miss_nxt;
      distinct_r  <= distinct_nxt;
      last_miss_r <= last_miss_nxt;
      seen_r      <= seen_nxt;
    end
  end

  assign access_total   = access_r;
  assign miss_total     = miss_r;
  assign distinct_total = distinct_r;

endmodule

// ----- design/set_assoc_cache_tag_model.sv -----
`timescale 1ns / 1ps
// Tag-only set-associative cache model.
// Requests: drive in_cycle_stamp and in_address with start high; the request
// is taken at the rising edge where start is high and busy is low.
// For each request, the edge that takes it reads the set row from the set
// RAM into its registered output, and the next cycle compares all ways in
// parallel, picks a victim on a miss and writes the updated row back. busy
// is high during that compare cycle, so a new request is taken only after
// the last one is through, for the read-modify-write of the single set RAM.
// The result shows on the out_ ports with out_valid high for exactly one
// cycle, raised at the edge that ends the compare cycle. The receiver
// takes it at the edge that ends the strobe and cannot stall:
// a result not taken in that cycle is gone, and the totals stay on the
// ports until the next result.
// Configuration: cfg_we with cfg_index and cfg_data writes one register at
// a clock edge; writes are meant for idle periods only.
// Reset (rst_n low, synchronous) restores the register defaults, zeroes the
// counters, seeds the LFSR and marks every set row as untouched, which is
// done by one flag per row at once; no clearing pass is needed.
module set_assoc_cache_tag_model #(
  parameter int MAX_SETS  = satm_pkg::DEF_MAX_SETS,
  parameter int WAYS      = satm_pkg::DEF_WAYS,
  parameter int ADDR_BITS = satm_pkg::DEF_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [satm_pkg::CYCLE_W-1:0]     in_cycle_stamp,
  input  logic [satm_pkg::ADDR_W-1:0]      in_address,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [satm_pkg::LAT_W-1:0]       out_latency,
  output logic [satm_pkg::CNT_W-1:0]       out_access_total,
  output logic [satm_pkg::CNT_W-1:0]       out_miss_total,
  output logic [satm_pkg::CNT_W-1:0]       out_distinct_miss_total,
  input  logic                             cfg_we,
  input  logic [satm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [satm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import satm_pkg::*;

  // Addresses wider than the request port carry no extra bits.
  localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * TAG_W + WAYS + WAYS * WAY_W;

  // Configuration registers.
  logic [SHIFT_W-1:0]  offset_bits_r, offset_bits_nxt;
  logic [SHIFT_W-1:0]  index_bits_r, index_bits_nxt;
  logic [POLICY_W-1:0] policy_r, policy_nxt;
  logic [LAT_W-1:0]    hit_lat_r, hit_lat_nxt;
  logic [LAT_W-1:0]    miss_penalty_r, miss_penalty_nxt;

  // Request tracking.
  logic               accept;
  logic               busy_r;
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  logic [CYCLE_W-1:0] cycle_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [LAT_W-1:0]   out_latency_r;

  // Address split.
  logic [TAG_W-1:0]   addr_m;
  logic [TAG_W-1:0]   addr_sh;
  logic [15:0]        idx_mask;
  logic [15:0]        idx;
  logic [SET_W-1:0]   set_idx;
  logic [SHIFT_W:0]   tag_shift;
  logic [TAG_W-1:0]   tag_in;

  logic [ROW_W-1:0]   row_rd, row_wr;
  logic               row_live;
  logic               hit;
  upd_t               ev;

  always_comb begin
    offset_bits_nxt  = offset_bits_r;
    index_bits_nxt   = index_bits_r;
    policy_nxt       = policy_r;
    hit_lat_nxt      = hit_lat_r;
    miss_penalty_nxt = miss_penalty_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_BITS: offset_bits_nxt  = cfg_data[SHIFT_W-1:0];
        CFG_INDEX_BITS:  index_bits_nxt   = cfg_data[SHIFT_W-1:0];
        CFG_POLICY:      policy_nxt       = cfg_data[POLICY_W-1:0];
        CFG_HIT_LAT:     hit_lat_nxt      = cfg_data[LAT_W-1:0];
        CFG_MISS_LAT:    miss_penalty_nxt = cfg_data[LAT_W-1:0];
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r  <= RST_OFFSET_BITS;
      index_bits_r   <= RST_INDEX_BITS;
      policy_r       <= POLICY_LRU;
      hit_lat_r      <= RST_HIT_LAT;
      miss_penalty_r <= RST_MISS_LAT;
    end else begin
      offset_bits_r  <= offset_bits_nxt;
      index_bits_r   <= index_bits_nxt;
      policy_r       <= policy_nxt;
      hit_lat_r      <= hit_lat_nxt;
      miss_penalty_r <= miss_penalty_nxt;
    end
  end

  // The set index is the field above the offset, reduced to the number of
  // sets built; the tag is everything above offset and index. Oversized
  // field settings simply shift more bits away.
  assign addr_m    = in_address[TAG_W-1:0];
  assign addr_sh   = addr_m >> offset_bits_r;
  assign idx_mask  = (16'd1 << index_bits_r) - 16'd1;
  assign idx       = addr_sh[15:0] & idx_mask;
  assign set_idx   = SET_W'(idx & 16'(MAX_SETS - 1));
  assign tag_shift = {1'b0, offset_bits_r} + {1'b0, index_bits_r};
  assign tag_in    = addr_m >> tag_shift;

  // busy covers the compare cycle; it also keeps the next read behind the
  // write-back of the row that may be the same set.
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r   <= set_idx;
      tag_r   <= tag_in;
      cycle_r <= in_cycle_stamp;
    end
    if (busy_r) begin
      out_hit_r     <= hit;
      out_latency_r <= hit ? hit_lat_r : miss_penalty_r;
    end
  end

  satm_set_ram #(
    .DEPTH (MAX_SETS),
    .AW    (SET_W),
    .DW    (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (set_idx),
    .rd_data (row_rd),
    .rd_live (row_live),
    .wr_en   (busy_r),
    .wr_addr (set_r),
    .wr_data (row_wr)
  );

  satm_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .ROW_W (ROW_W)
  ) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (busy_r),
    .policy   (policy_r),
    .tag      (tag_r),
    .row_in   (row_rd),
    .row_live (row_live),
    .hit      (hit),
    .row_out  (row_wr)
  );

  assign ev.fire = busy_r;
  assign ev.miss = !hit;

  // The counters move at the same edge that raises out_valid, so they can
  // drive the total ports directly.
  satm_stats u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .ev             (ev),
    .cycle_stamp    (cycle_r),
    .miss_latency   (miss_penalty_r),
    .access_total   (out_access_total),
    .miss_total     (out_miss_total),
    .distinct_total (out_distinct_miss_total)
  );

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_latency = out_latency_r;

endmodule

// ----- design/satm_checker.sv -----
`timescale 1ns / 1ps
module satm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_hit,
  input logic [satm_pkg::CNT_W-1:0]      out_access_total,
  input logic [satm_pkg::CNT_W-1:0]      out_miss_total
);

  // A taken request raises busy for the compare cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after a request was taken");

  // The compare cycle ends in a result strobe and frees the request port.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("compare cycle did not end in a result");

  // Every result counts one more access.
  a_access_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_access_total == $past(out_access_total) + 1'b1)
    else $error("access total did not advance by one");

  // Misses advance the miss total, hits leave it alone.
  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_miss_total == $past(out_miss_total) + {63'd0, !out_hit})
    else $error("miss total does not match the hit flag");

endmodule

bind set_assoc_cache_tag_model satm_checker u_satm_checker (.*);
